// ----- rtl/a64ex_pkg.sv -----
package a64ex_pkg;

	localparam int XLEN = 64;
	localparam int IMM_W = 32;
	localparam int REG_W = 5;
	localparam int MODE_W = 4;
	localparam int AK_W = 2;
	localparam int COND_W = 4;
	localparam int FLAGS_W = 4;

	// General registers X0..X30; number 31 is XZR or SP depending on use.
	localparam int NUM_GPR = 31;
	localparam int GPR_SLOTS = 2 ** REG_W;
	localparam logic [REG_W-1:0] REG_ZR_SP = REG_W'(31);

	// Data memory holds 64-bit words; byte address bits [2:0] are dropped.
	localparam int MEM_WORDS = 256;
	localparam int MEM_AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int WORD_SHIFT = 3;

	// Flag bit positions in the NZCV nibble.
	localparam int FLAG_N = 3;
	localparam int FLAG_Z = 2;
	localparam int FLAG_C = 1;
	localparam int FLAG_V = 0;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD_IMM = 4'd0,
		MODE_SUB_IMM = 4'd1,
		MODE_ADD_REG = 4'd2,
		MODE_SUB_REG = 4'd3,
		MODE_LOAD    = 4'd4,
		MODE_STORE   = 4'd5,
		MODE_BRANCH  = 4'd6,
		MODE_CBRANCH = 4'd7,
		MODE_NONE    = 4'd8
	} mode_t;

	typedef enum logic [AK_W-1:0] {
		AK_OFFSET = 2'd0,
		AK_PRE    = 2'd1,
		AK_POST   = 2'd2
	} addr_kind_t;

	localparam logic [COND_W-1:0] COND_EQ = 4'h0;
	localparam logic [COND_W-1:0] COND_NE = 4'h1;
	localparam logic [COND_W-1:0] COND_CC = 4'h3;
	localparam logic [COND_W-1:0] COND_MI = 4'h4;
	localparam logic [COND_W-1:0] COND_PL = 4'h5;
	localparam logic [COND_W-1:0] COND_VS = 4'h6;
	localparam logic [COND_W-1:0] COND_VC = 4'h7;
	localparam logic [COND_W-1:0] COND_HI = 4'h8;
	localparam logic [COND_W-1:0] COND_GE = 4'hA;
	localparam logic [COND_W-1:0] COND_LT = 4'hB;

	// One register file write: used for the write port and for bypassing.
	typedef struct packed {
		logic             en;
		logic [REG_W-1:0] addr;
		logic [XLEN-1:0]  data;
	} rf_wr_t;

	// Evaluates a condition code against NZCV; unsupported codes never hold.
	function automatic logic cond_holds(input logic [COND_W-1:0] cc,
		input logic [FLAGS_W-1:0] f);
		logic hold;
		hold = 1'b0;
		unique case (cc)
			COND_EQ: hold = f[FLAG_Z];
			COND_NE: hold = !f[FLAG_Z];
			COND_CC: hold = !f[FLAG_C];
			COND_MI: hold = f[FLAG_N];
			COND_PL: hold = !f[FLAG_N];
			COND_VS: hold = f[FLAG_V];
			COND_VC: hold = !f[FLAG_V];
			COND_HI: hold = f[FLAG_C] && !f[FLAG_Z];
			COND_GE: hold = f[FLAG_N] == f[FLAG_V];
			COND_LT: hold = f[FLAG_N] != f[FLAG_V];
			default: hold = 1'b0;
		endcase
		return hold;
	endfunction

endpackage

// ----- rtl/a64ex_ram.sv -----
module a64ex_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read in the same cycle as a write to that address returns the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/a64ex_regfile.sv -----
module a64ex_regfile
	import a64ex_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  rf_wr_t           wr,
	input  logic [REG_W-1:0] raddr_a,
	input  logic [REG_W-1:0] raddr_b,
	output logic [XLEN-1:0]  rdata_a,
	output logic [XLEN-1:0]  rdata_b
);

	// Two copies of the register array give two read ports; both take every write.
	logic [GPR_SLOTS-1:0] valid_q;
	logic [REG_W-1:0]     raddr_a_q;
	logic [REG_W-1:0]     raddr_b_q;
	logic [XLEN-1:0]      ram_a;
	logic [XLEN-1:0]      ram_b;

	a64ex_ram #(
		.WIDTH (XLEN),
		.DEPTH (NUM_GPR)
	) u_ram_a (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (1'b1),
		.raddr (raddr_a),
		.rdata (ram_a)
	);

	a64ex_ram #(
		.WIDTH (XLEN),
		.DEPTH (NUM_GPR)
	) u_ram_b (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (1'b1),
		.raddr (raddr_b),
		.rdata (ram_b)
	);

	// A register that was never written reads as zero after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		raddr_a_q <= raddr_a;
		raddr_b_q <= raddr_b;
	end

	assign rdata_a = valid_q[raddr_a_q] ? ram_a : '0;
	assign rdata_b = valid_q[raddr_b_q] ? ram_b : '0;

endmodule

// ----- rtl/arm64_subset_execute_stage.sv -----
// Execute stage for a small AArch64 integer subset: it takes one decoded
// instruction per request and returns one result per request, in order.
// Supported are add and subtract (immediate or register, optional NZC update),
// 64-bit load and store with offset, pre-index or post-index addressing, and
// unconditional and conditional PC-relative branches. After reset the block
// zeroes all MEM_WORDS (256) words of the data memory with instr_ready low.
// Afterwards it accepts one instruction per cycle while results are taken;
// a result passes the stage 1 and stage 2 registers. A load that also writes
// back its base register (base other than SP and other than the destination)
// needs two register file writes, so the instruction behind it waits; all
// else sustains one instruction per cycle while results are taken, set by the
// single write port of the register file. Dependent instructions are served
// by bypassing, including a load result feeding the very next instruction.
module arm64_subset_execute_stage
	import a64ex_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    instr_valid,
	output logic                    instr_ready,
	input  logic [MODE_W-1:0]       mode,
	input  logic [REG_W-1:0]        dest_reg,
	input  logic [REG_W-1:0]        first_src_reg,
	input  logic [REG_W-1:0]        second_src_reg,
	input  logic signed [IMM_W-1:0] immediate,
	input  logic                    update_flags,
	input  logic [AK_W-1:0]         addr_kind,
	input  logic [COND_W-1:0]       cond_code,

	output logic                    result_valid,
	input  logic                    result_ready,
	output logic [XLEN-1:0]         result_value,
	output logic                    branch_taken,
	output logic [FLAGS_W-1:0]      flags_out,
	output logic [XLEN-1:0]         pc_out
);

	// Stage 1: registered instruction; register file data arrives here.
	logic                    s1_valid;
	logic [MODE_W-1:0]       mode_s1;
	logic [REG_W-1:0]        rd_s1;
	logic [REG_W-1:0]        rn_s1;
	logic [REG_W-1:0]        rm_s1;
	logic signed [IMM_W-1:0] imm_s1;
	logic                    setf_s1;
	logic [AK_W-1:0]         ak_s1;
	logic [COND_W-1:0]       cc_s1;

	// Stage 2: result register plus the register writes still owed.
	logic                    s2_out_q;
	logic                    s2_rd_q;
	logic                    s2_base_q;
	logic                    is_load_s2;
	logic [XLEN-1:0]         res_s2;
	logic                    taken_s2;
	logic [FLAGS_W-1:0]      flags_s2;
	logic [XLEN-1:0]         pc_s2;
	logic [REG_W-1:0]        rd_s2;
	logic [REG_W-1:0]        rn_s2;
	logic [XLEN-1:0]         wb_s2;

	// Architectural state kept in flops.
	logic [XLEN-1:0]         sp_q;
	logic [XLEN-1:0]         pc_q;
	logic [FLAGS_W-1:0]      flags_q;

	// Data memory clearing sweep after reset.
	logic                    clr_busy_q;
	logic [MEM_AW-1:0]       clr_idx_q;

	// Handshake and flow control.
	logic                    accept;
	logic                    s1_adv;
	logic                    s2_free;
	logic                    s1_hold;

	// Register file access and bypass.
	rf_wr_t                  rf_wr;
	rf_wr_t                  lw_q;
	rf_wr_t                  pend_rd;
	rf_wr_t                  pend_base;
	logic [REG_W-1:0]        rf_raddr_a;
	logic [REG_W-1:0]        rf_raddr_b;
	logic [REG_W-1:0]        rb_s1;
	logic [XLEN-1:0]         rf_a;
	logic [XLEN-1:0]         rf_b;
	logic [XLEN-1:0]         gpr_a;
	logic [XLEN-1:0]         gpr_b;
	logic [XLEN-1:0]         rd_val;

	// Stage 1 decode and datapath.
	logic                    is_arith;
	logic                    is_sub;
	logic                    is_imm_form;
	logic                    is_load;
	logic                    is_store;
	logic                    is_branch;
	logic                    is_cbranch;
	logic [XLEN-1:0]         imm64;
	logic [XLEN-1:0]         op_a;
	logic [XLEN-1:0]         op_b;
	logic [XLEN:0]           sum;
	logic [XLEN-1:0]         base;
	logic [XLEN-1:0]         ea;
	logic [XLEN-1:0]         mem_addr;
	logic                    wb_en;
	logic [XLEN-1:0]         store_data;
	logic                    take;
	logic [FLAGS_W-1:0]      flags_nxt;
	logic [XLEN-1:0]         res_nxt;

	// Data memory port.
	logic                    mem_we;
	logic [MEM_AW-1:0]       mem_waddr;
	logic [XLEN-1:0]         mem_wdata;
	logic                    mem_re;
	logic [MEM_AW-1:0]       mem_idx;
	logic [XLEN-1:0]         mem_rdata;

	// Newest pending write to a register wins over older ones and the array.
	function automatic logic [XLEN-1:0] fwd_gpr(input logic [REG_W-1:0] a,
		input logic [XLEN-1:0] ram_val, input rf_wr_t w0, input rf_wr_t w1,
		input rf_wr_t w2);
		logic [XLEN-1:0] v;
		v = ram_val;
		if (w2.en && (w2.addr == a)) v = w2.data;
		if (w1.en && (w1.addr == a)) v = w1.data;
		if (w0.en && (w0.addr == a)) v = w0.data;
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Flow control. Stage 2 is free at a clock edge when its result has
	// been (or is being) taken and at most one register write remains,
	// which is then done at that edge.
	// ------------------------------------------------------------------
	assign s2_free     = (!s2_out_q || result_ready) && !(s2_base_q && s2_rd_q);
	assign s1_adv      = s1_valid && s2_free;
	assign s1_hold     = s1_valid && !s1_adv;
	assign instr_ready = !clr_busy_q && (!s1_valid || s1_adv);
	assign accept      = instr_valid && instr_ready;

	// ------------------------------------------------------------------
	// Register file. The array is read every cycle: at stage 1's addresses
	// while stage 1 holds, otherwise at the incoming request's addresses,
	// so a stalled instruction keeps seeing fresh contents. Writes made at
	// the last edge (lw_q) and writes still owed by stage 2 are bypassed.
	// ------------------------------------------------------------------
	assign rb_s1      = (mode_s1 == MODE_STORE) ? rd_s1 : rm_s1;
	assign rf_raddr_a = s1_hold ? rn_s1 : first_src_reg;
	assign rf_raddr_b = s1_hold ? rb_s1 :
		((mode == MODE_STORE) ? dest_reg : second_src_reg);

	a64ex_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (rf_wr),
		.raddr_a (rf_raddr_a),
		.raddr_b (rf_raddr_b),
		.rdata_a (rf_a),
		.rdata_b (rf_b)
	);

	// Stage 2 writes the base first, then the destination, one per cycle.
	assign rd_val = is_load_s2 ? mem_rdata : res_s2;

	always_comb begin
		pend_rd.en     = s2_rd_q;
		pend_rd.addr   = rd_s2;
		pend_rd.data   = rd_val;
		pend_base.en   = s2_base_q;
		pend_base.addr = rn_s2;
		pend_base.data = wb_s2;
		rf_wr.en       = s2_base_q || s2_rd_q;
		rf_wr.addr     = s2_base_q ? rn_s2 : rd_s2;
		rf_wr.data     = s2_base_q ? wb_s2 : rd_val;
	end

	assign gpr_a = fwd_gpr(rn_s1, rf_a, pend_rd, pend_base, lw_q);
	assign gpr_b = fwd_gpr(rb_s1, rf_b, pend_rd, pend_base, lw_q);

	// ------------------------------------------------------------------
	// Stage 1 decode.
	// ------------------------------------------------------------------
	always_comb begin
		is_arith    = 1'b0;
		is_sub      = 1'b0;
		is_imm_form = 1'b0;
		is_load     = 1'b0;
		is_store    = 1'b0;
		is_branch   = 1'b0;
		is_cbranch  = 1'b0;
		unique case (mode_s1)
			MODE_ADD_IMM: begin
				is_arith    = 1'b1;
				is_imm_form = 1'b1;
			end
			MODE_SUB_IMM: begin
				is_arith    = 1'b1;
				is_sub      = 1'b1;
				is_imm_form = 1'b1;
			end
			MODE_ADD_REG: begin
				is_arith = 1'b1;
			end
			MODE_SUB_REG: begin
				is_arith = 1'b1;
				is_sub   = 1'b1;
			end
			MODE_LOAD: begin
				is_load = 1'b1;
			end
			MODE_STORE: begin
				is_store = 1'b1;
			end
			MODE_BRANCH: begin
				is_branch = 1'b1;
			end
			MODE_CBRANCH: begin
				is_cbranch = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign imm64 = {{(XLEN - IMM_W){imm_s1[IMM_W-1]}}, imm_s1};

	// ------------------------------------------------------------------
	// Arithmetic. Register 31 reads as zero here. Subtraction is a + ~b + 1,
	// whose carry out is exactly "a >= b" unsigned; for addition the carry
	// out is the unsigned overflow.
	// ------------------------------------------------------------------
	assign op_a = (rn_s1 == REG_ZR_SP) ? '0 : gpr_a;

	always_comb begin
		if (is_imm_form) begin
			op_b = imm64;
		end else if (rm_s1 == REG_ZR_SP) begin
			op_b = '0;
		end else begin
			op_b = gpr_b;
		end
	end

	assign sum = {1'b0, op_a} + {1'b0, (is_sub ? ~op_b : op_b)} + (XLEN + 1)'(is_sub);

	always_comb begin
		flags_nxt = flags_q;
		if (is_arith && setf_s1) begin
			flags_nxt[FLAG_N] = sum[XLEN-1];
			flags_nxt[FLAG_Z] = (sum[XLEN-1:0] == '0);
			flags_nxt[FLAG_C] = sum[XLEN];
		end
	end

	// ------------------------------------------------------------------
	// Load and store addressing. Register 31 as base or store data is SP.
	// Post-index accesses at the old base; both indexed forms write the
	// base plus offset back. Store data is read after that write-back, so
	// storing the base register itself stores the updated value.
	// ------------------------------------------------------------------
	assign base     = (rn_s1 == REG_ZR_SP) ? sp_q : gpr_a;
	assign ea       = base + imm64;
	assign wb_en    = (ak_s1 == AK_PRE) || (ak_s1 == AK_POST);
	assign mem_addr = (ak_s1 == AK_POST) ? base : ea;
	assign mem_idx  = mem_addr[WORD_SHIFT +: MEM_AW];

	always_comb begin
		if (wb_en && (rd_s1 == rn_s1)) begin
			store_data = ea;
		end else if (rd_s1 == REG_ZR_SP) begin
			store_data = sp_q;
		end else begin
			store_data = gpr_b;
		end
	end

	// A zero offset counts as not taken and leaves the PC alone.
	assign take = (is_branch || (is_cbranch && cond_holds(cc_s1, flags_q))) &&
		(imm_s1 != '0);

	always_comb begin
		if (is_arith) begin
			res_nxt = sum[XLEN-1:0];
		end else if (is_store) begin
			res_nxt = store_data;
		end else begin
			res_nxt = '0;
		end
	end

	// ------------------------------------------------------------------
	// Data memory. Stores write and loads read as stage 1 moves on; load
	// data is then valid throughout stage 2. During the clearing sweep the
	// write port zeroes one word per cycle.
	// ------------------------------------------------------------------
	assign mem_we    = clr_busy_q || (s1_adv && is_store);
	assign mem_waddr = clr_busy_q ? clr_idx_q : mem_idx;
	assign mem_wdata = clr_busy_q ? '0 : store_data;
	assign mem_re    = s1_adv && is_load;

	a64ex_ram #(
		.WIDTH (XLEN),
		.DEPTH (MEM_WORDS)
	) u_dmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_idx),
		.rdata (mem_rdata)
	);

	// ------------------------------------------------------------------
	// Control and architectural state.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid   <= 1'b0;
			s2_out_q   <= 1'b0;
			s2_rd_q    <= 1'b0;
			s2_base_q  <= 1'b0;
			lw_q       <= '0;
			sp_q       <= '0;
			pc_q       <= '0;
			flags_q    <= '0;
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else begin
			lw_q <= rf_wr;

			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + MEM_AW'(1);
				if (clr_idx_q == MEM_AW'(MEM_WORDS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end

			if (accept) begin
				s1_valid <= 1'b1;
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
			end

			if (s1_adv) begin
				s2_out_q  <= 1'b1;
				s2_rd_q   <= (is_arith || is_load) && (rd_s1 != REG_ZR_SP);
				s2_base_q <= (is_load || is_store) && wb_en && (rn_s1 != REG_ZR_SP) &&
					!(is_load && (rn_s1 == rd_s1));
				flags_q   <= flags_nxt;
				if (take) begin
					pc_q <= pc_q + imm64;
				end
				if ((is_load || is_store) && wb_en && (rn_s1 == REG_ZR_SP)) begin
					sp_q <= ea;
				end
			end else begin
				s2_out_q  <= s2_out_q && !result_ready;
				s2_base_q <= 1'b0;
				s2_rd_q   <= s2_rd_q && s2_base_q;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			rd_s1   <= dest_reg;
			rn_s1   <= first_src_reg;
			rm_s1   <= second_src_reg;
			imm_s1  <= immediate;
			setf_s1 <= update_flags;
			ak_s1   <= addr_kind;
			cc_s1   <= cond_code;
		end
		if (s1_adv) begin
			is_load_s2 <= is_load;
			res_s2     <= res_nxt;
			taken_s2   <= take;
			flags_s2   <= flags_nxt;
			pc_s2      <= take ? (pc_q + imm64) : pc_q;
			rd_s2      <= rd_s1;
			rn_s2      <= rn_s1;
			wb_s2      <= ea;
		end
	end

	assign result_valid = s2_out_q;
	assign result_value = is_load_s2 ? mem_rdata : res_s2;
	assign branch_taken = taken_s2;
	assign flags_out    = flags_s2;
	assign pc_out       = pc_s2;

endmodule

// ----- rtl/a64ex_checker.sv -----
module a64ex_checker
	import a64ex_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               instr_valid,
	input logic               instr_ready,
	input logic               result_valid,
	input logic               result_ready,
	input logic [XLEN-1:0]    result_value,
	input logic               branch_taken,
	input logic [FLAGS_W-1:0] flags_out,
	input logic [XLEN-1:0]    pc_out
);

	logic            in_acc;
	logic            out_acc;
	logic [1:0]      open_q;
	logic [XLEN-1:0] last_pc_q;

	assign in_acc  = instr_valid && instr_ready;
	assign out_acc = result_valid && result_ready;

	// Requests accepted but not yet answered, and the PC of the last result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= '0;
			last_pc_q <= '0;
		end else begin
			if (in_acc && !out_acc) begin
				open_q <= open_q + 2'd1;
			end else if (out_acc && !in_acc) begin
				open_q <= open_q - 2'd1;
			end
			if (out_acc) begin
				last_pc_q <= pc_out;
			end
		end
	end

	// A result never shows up without a request behind it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (open_q != 2'd0))
		else $error("result without an outstanding request");

	// A waiting result holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_value) &&
		$stable(pc_out) && $stable(flags_out) && $stable(branch_taken))
		else $error("result changed while stalled");

	// The V flag is never written.
	a_v_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !flags_out[FLAG_V])
		else $error("V flag set");

	// The PC moves only on a taken branch, and a taken branch always moves it.
	a_pc_still: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !branch_taken |-> (pc_out == last_pc_q))
		else $error("PC changed without a taken branch");

	a_pc_moved: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && branch_taken |-> (pc_out != last_pc_q))
		else $error("taken branch left the PC unchanged");

endmodule

bind arm64_subset_execute_stage a64ex_checker u_a64ex_checker (.*);
